@@ src/f64v_pkg.sv @@
`default_nettype none

package f64v_pkg;

  // modulus of both running sums, 2^32 - 1
  localparam logic [31:0] MOD_ONES = 32'hffff_ffff;

  // word position in the block, saturating at WPOS_SAT
  localparam logic [1:0] WPOS_LOW  = 2'd0;
  localparam logic [1:0] WPOS_HIGH = 2'd1;
  localparam logic [1:0] WPOS_SAT  = 2'd3;

  // sums, stored checksum and too-short flag of a finished block
  typedef struct packed {
    logic [31:0] sum_low;
    logic [31:0] sum_high;
    logic [31:0] stored_low;
    logic [31:0] stored_high;
    logic        too_short;
  } fin_t;

  // a + b modulo 2^32 - 1, for a + b below twice the modulus
  function automatic logic [31:0] fold_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    logic [32:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = s - {1'b0, MOD_ONES};
    fold_add = (s >= {1'b0, MOD_ONES}) ? t[31:0] : s[31:0];
  endfunction

endpackage

`default_nettype wire

@@ src/f64v_accum.sv @@
`default_nettype none

module f64v_accum (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [31:0]   data_word,
  input  wire logic          last_word,
  output logic               fin_valid,
  input  wire logic          fin_ready,
  output f64v_pkg::fin_t     fin
);

  // input register
  logic        word_valid;
  logic [31:0] word;
  logic        word_last;

  // running block state
  logic [31:0] sum_low;
  logic [31:0] sum_high;
  logic [31:0] stored_low;
  logic [31:0] stored_high;
  logic [1:0]  word_position;

  logic [31:0] sum_low_next;
  logic [31:0] sum_high_next;
  logic [31:0] stored_low_next;
  logic [31:0] stored_high_next;
  logic [1:0]  word_position_next;

  logic fin_load;
  logic drain;

  // a last word needs the finish register free, other words never wait
  assign fin_load = !fin_valid || fin_ready;
  assign drain    = word_valid && (!word_last || fin_load);
  assign in_ready = !word_valid || drain;

  always_comb begin
    sum_low_next     = sum_low;
    sum_high_next    = sum_high;
    stored_low_next  = stored_low;
    stored_high_next = stored_high;
    case (word_position)
      f64v_pkg::WPOS_LOW: begin
        stored_low_next = word;
      end
      f64v_pkg::WPOS_HIGH: begin
        stored_high_next = word;
      end
      default: begin
        sum_low_next  = f64v_pkg::fold_add(sum_low, word);
        sum_high_next = f64v_pkg::fold_add(sum_high, sum_low_next);
      end
    endcase
    word_position_next = (word_position == f64v_pkg::WPOS_SAT) ? word_position
                                                               : word_position + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ready) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word      <= data_word;
      word_last <= last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_low       <= '0;
      sum_high      <= '0;
      stored_low    <= '0;
      stored_high   <= '0;
      word_position <= f64v_pkg::WPOS_LOW;
    end else if (drain) begin
      if (word_last) begin
        sum_low       <= '0;
        sum_high      <= '0;
        stored_low    <= '0;
        stored_high   <= '0;
        word_position <= f64v_pkg::WPOS_LOW;
      end else begin
        sum_low       <= sum_low_next;
        sum_high      <= sum_high_next;
        stored_low    <= stored_low_next;
        stored_high   <= stored_high_next;
        word_position <= word_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_load) begin
      fin_valid <= drain && word_last;
    end
  end

  always_ff @(posedge clk) begin
    if (drain && word_last) begin
      fin.sum_low     <= sum_low_next;
      fin.sum_high    <= sum_high_next;
      fin.stored_low  <= stored_low_next;
      fin.stored_high <= stored_high_next;
      fin.too_short   <= (word_position == f64v_pkg::WPOS_LOW)
                      || (word_position == f64v_pkg::WPOS_HIGH);
    end
  end

endmodule

`default_nettype wire

@@ src/f64v_check.sv @@
`default_nettype none

module f64v_check (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fin_valid,
  output logic               fin_ready,
  input  wire f64v_pkg::fin_t fin,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        check_low,
  output logic [31:0]        check_high,
  output logic               checksum_match,
  output logic               block_too_short
);

  logic [31:0] low_fold;
  logic [31:0] c1;
  logic [31:0] c2;

  // modulus minus a value below the modulus is its complement
  always_comb begin
    low_fold = f64v_pkg::fold_add(fin.sum_low, fin.sum_high);
    c1       = ~low_fold;
    c2       = ~f64v_pkg::fold_add(fin.sum_low, c1);
  end

  assign fin_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_ready) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && fin_valid) begin
      check_low       <= c1;
      check_high      <= c2;
      checksum_match  <= (c1 == fin.stored_low) && (c2 == fin.stored_high);
      block_too_short <= fin.too_short;
    end
  end

endmodule

`default_nettype wire

@@ src/block_fletcher64_verify.sv @@
// channel   handshake              payload
// input     in_valid / in_ready    data_word[31:0], last_word
// output    out_valid / out_ready  check_low[31:0], check_high[31:0],
//                                  checksum_match, block_too_short
//
// one word is accepted per cycle unless a last word waits on a stalled output;
// the running sums fold once per word after the two stored checksum words
// rst is synchronous and clears the valid flags and the block state
// a stalled output holds the next last word; others flow until it is registered
`default_nettype none

module block_fletcher64_verify (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] data_word,
  input  wire logic        last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      check_low,
  output logic [31:0]      check_high,
  output logic             checksum_match,
  output logic             block_too_short
);

  // finished block travelling from the accumulator to the check stage
  logic           fin_valid;
  logic           fin_ready;
  f64v_pkg::fin_t fin;

  // input register, stored checksum capture and the two running sums
  f64v_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_word (data_word),
    .last_word (last_word),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  // check words, compare against the stored checksum, result register
  f64v_check u_check (
    .clk             (clk),
    .rst             (rst),
    .fin_valid       (fin_valid),
    .fin_ready       (fin_ready),
    .fin             (fin),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .check_low       (check_low),
    .check_high      (check_high),
    .checksum_match  (checksum_match),
    .block_too_short (block_too_short)
  );

endmodule

`default_nettype wire
